### design/ptint_pkg.sv
// Shared constants, types and codes of the threshold interpolator.
package ptint_pkg;

	localparam int TABLE_ENTRIES = 100;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int SLOT_W        = $clog2(TABLE_ENTRIES + 1);
	localparam int DATA_W        = 24;
	localparam int KIDX_W        = 7;
	localparam int POD_W         = 15;
	localparam int FRAC_BITS     = 8;
	localparam int SUM_W         = (SLOT_W + FRAC_BITS + 1 > POD_W) ?
	                               SLOT_W + FRAC_BITS + 1 : POD_W;

	localparam logic [POD_W-1:0] POD_ZERO = 15'd0;
	localparam logic [POD_W-1:0] POD_ONE  = 15'd256;
	localparam logic [POD_W-1:0] POD_TOP  = 15'd25574;
	localparam int               POD_MAX  = (TABLE_ENTRIES * 256 > 32767) ?
	                                        32767 : TABLE_ENTRIES * 256;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_QUERY,
		OP_SKIP
	} op_t;

	typedef struct packed {
		op_t                      op;
		logic [IDX_W-1:0]         addr;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIRST,
		ST_LAST,
		ST_PROBE,
		ST_CMP,
		ST_RDHI,
		ST_RDLO,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} st_t;

endpackage

### design/pod_threshold_interpolator.sv
// Top level: margin in dB to probability of detection, by table search and interpolation.
//
// Use: items enter through push/full; kind 0 writes one threshold entry
// (entry_index, entry_value), kind 1 asks for the detection probability of
// margin_db. Writes give no result; each query gives one pod_percent item
// (percent, 8 fraction bits) on the result side, read with empty/pop.
// Entries with entry_index at or beyond the table size are dropped. The
// table must be loaded, ascending, before a query reads it.
//
// Flow: a write is retired by the back end in the cycle it is taken, so
// writes stream at one per cycle while the back end is idle. A query
// settled by the first or last entry goes from ST_FIRST and ST_LAST
// straight to ST_DONE; one that needs the full search runs six or seven
// binary search steps (ST_PROBE, ST_CMP; one table read port with
// registered data), fetches the bracketing entries (ST_RDHI, ST_RDLO,
// ST_PREP), where needed runs the bit-serial divider for the fraction
// (ST_DIV) and hands the result over in ST_DONE. The back end works on one
// item at a time, so it takes no new item until the last result is handed over.
//
// Reset clears both queues and the sequencer; the table is not cleared.
// When pop is held low, the two-entry result queue fills, the back end
// waits with its finished result, then the command queue fills and full rises.
module pod_threshold_interpolator import ptint_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic                     kind,
	input  logic [KIDX_W-1:0]        entry_index,
	input  logic signed [DATA_W-1:0] entry_value,
	input  logic signed [DATA_W-1:0] margin_db,
	output logic                     empty,
	input  logic                     pop,
	output logic [POD_W-1:0]         pod_percent
);

	logic             cmd_valid;
	cmd_t             cmd;
	logic             cmd_pop;
	logic             res_full;
	logic             res_push;
	logic [POD_W-1:0] res_data;

	// front: classify and queue incoming items
	ptint_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.kind        (kind),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.margin_db   (margin_db),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop)
	);

	// back: table writes, search and interpolation
	ptint_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	// finished results wait here for the receiver
	ptint_rq u_rq (
		.clk         (clk),
		.arst_n      (arst_n),
		.res_push    (res_push),
		.res_data    (res_data),
		.res_full    (res_full),
		.empty       (empty),
		.pop         (pop),
		.pod_percent (pod_percent)
	);

endmodule

### design/ptint_front.sv
// Front end: takes items, classifies them and holds them in a two-entry command queue.
module ptint_front import ptint_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic                     kind,
	input  logic [KIDX_W-1:0]        entry_index,
	input  logic signed [DATA_W-1:0] entry_value,
	input  logic signed [DATA_W-1:0] margin_db,
	output logic                     cmd_valid,
	output cmd_t                     cmd,
	input  logic                     cmd_pop
);

	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       do_push;
	logic       do_pop;

	// classify: queries carry the margin, out-of-range writes are dropped
	always_comb begin
		cls.addr  = IDX_W'(entry_index);
		cls.value = kind ? margin_db : entry_value;
		if (kind) begin
			cls.op = OP_QUERY;
		end else if (int'(entry_index) < TABLE_ENTRIES) begin
			cls.op = OP_WRITE;
		end else begin
			cls.op = OP_SKIP;
		end
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### design/ptint_rq.sv
// Two-entry result queue feeding the result ports.
module ptint_rq import ptint_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_push,
	input  logic [POD_W-1:0] res_data,
	output logic             res_full,
	output logic             empty,
	input  logic             pop,
	output logic [POD_W-1:0] pod_percent
);

	logic [POD_W-1:0] ent_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign res_full    = (cnt_q == 2'd2);
	assign empty       = (cnt_q == 2'd0);
	assign pod_percent = ent_q[rd_ptr_q];
	assign do_push     = res_push && !res_full;
	assign do_pop      = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= res_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### design/ptint_back.sv
// Back end: threshold table, binary search sequencer and serial fraction divider.
module ptint_back import ptint_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  cmd_t             cmd,
	output logic             cmd_pop,
	input  logic             res_full,
	output logic             res_push,
	output logic [POD_W-1:0] res_data
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	logic signed [DATA_W-1:0] mem [TABLE_ENTRIES];
	logic signed [DATA_W-1:0] rd_data_q;
	logic [IDX_W-1:0]         rd_addr;
	logic                     mem_we;

	st_t                      state_q, state_d;
	logic signed [DATA_W-1:0] margin_q;
	logic signed [DATA_W-1:0] hi_q;
	logic                     below_q;
	logic                     eq0_q;
	logic [SLOT_W-1:0]        first_q, first_d;
	logic [SLOT_W-1:0]        count_q, count_d;
	logic [DATA_W-1:0]        rem_q, rem_d;
	logic [DATA_W-1:0]        den_q;
	logic [FRAC_BITS-1:0]     quo_q, quo_d;
	logic [2:0]               bit_cnt_q;
	logic [POD_W-1:0]         res_q, res_d;
	logic                     res_ld;
	logic                     div_start;

	logic [SLOT_W-1:0]        half;
	logic [SLOT_W-1:0]        probe;
	logic signed [DATA_W:0]   num_w;
	logic signed [DATA_W:0]   den_w;
	logic [DATA_W:0]          shifted;
	logic [DATA_W:0]          trial;
	logic                     take;

	function automatic logic [POD_W-1:0] pod_of(input logic [SLOT_W-1:0] slot,
	                                            input logic [FRAC_BITS:0] frac);
		logic [SUM_W-1:0] s;
		s = (SUM_W'(slot) << FRAC_BITS) + SUM_W'(frac);
		return s[POD_W-1:0];
	endfunction

	assign half    = count_q >> 1;
	assign probe   = first_q + half;
	assign num_w   = {margin_q[DATA_W-1], margin_q} - {rd_data_q[DATA_W-1], rd_data_q};
	assign den_w   = {hi_q[DATA_W-1], hi_q} - {rd_data_q[DATA_W-1], rd_data_q};
	assign shifted = {rem_q, 1'b0};
	assign trial   = shifted - {1'b0, den_q};
	assign take    = (shifted >= {1'b0, den_q});
	assign rem_d   = take ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
	assign quo_d   = {quo_q[FRAC_BITS-2:0], take};
	assign res_data = res_q;

	// table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cmd.addr] <= cmd.value;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		mem_we    = 1'b0;
		rd_addr   = '0;
		first_d   = first_q;
		count_d   = count_q;
		res_ld    = 1'b0;
		res_d     = res_q;
		res_push  = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						OP_WRITE: mem_we = 1'b1;
						OP_QUERY: state_d = ST_FIRST;
						default:  mem_we = 1'b0;
					endcase
				end
			end
			ST_FIRST: begin
				rd_addr = LAST_IDX;
				state_d = ST_LAST;
			end
			ST_LAST: begin
				// early outcomes from the first and last entries
				if (below_q) begin
					res_ld  = 1'b1;
					res_d   = POD_ZERO;
					state_d = ST_DONE;
				end else if (eq0_q) begin
					res_ld  = 1'b1;
					res_d   = POD_ONE;
					state_d = ST_DONE;
				end else if (margin_q >= rd_data_q) begin
					res_ld  = 1'b1;
					res_d   = POD_TOP;
					state_d = ST_DONE;
				end else begin
					first_d = '0;
					count_d = SLOT_W'(TABLE_ENTRIES);
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				rd_addr = probe[IDX_W-1:0];
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (rd_data_q < margin_q) begin
					first_d = probe + SLOT_W'(1);
					count_d = count_q - half - SLOT_W'(1);
				end else begin
					count_d = half;
				end
				state_d = (count_d == '0) ? ST_RDHI : ST_PROBE;
			end
			ST_RDHI: begin
				if (first_q == '0) begin
					res_ld  = 1'b1;
					res_d   = POD_ZERO;
					state_d = ST_DONE;
				end else if (int'(first_q) >= TABLE_ENTRIES) begin
					res_ld  = 1'b1;
					res_d   = POD_TOP;
					state_d = ST_DONE;
				end else begin
					rd_addr = first_q[IDX_W-1:0];
					state_d = ST_RDLO;
				end
			end
			ST_RDLO: begin
				rd_addr = IDX_W'(first_q - SLOT_W'(1));
				state_d = ST_PREP;
			end
			ST_PREP: begin
				// rd_data_q holds the entry below, hi_q the entry found
				if (!(den_w > 0 && num_w > 0)) begin
					res_ld  = 1'b1;
					res_d   = pod_of(first_q, '0);
					state_d = ST_DONE;
				end else if (num_w >= den_w) begin
					res_ld  = 1'b1;
					res_d   = pod_of(first_q, (FRAC_BITS+1)'(256));
					state_d = ST_DONE;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (bit_cnt_q == 3'd7) begin
					res_ld  = 1'b1;
					res_d   = pod_of(first_q, {1'b0, quo_d});
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		first_q <= first_d;
		count_q <= count_d;
		if (res_ld) begin
			res_q <= res_d;
		end
		if (state_q == ST_IDLE) begin
			margin_q <= cmd.value;
		end
		if (state_q == ST_FIRST) begin
			below_q <= (margin_q > 24'sd0) || (margin_q < rd_data_q);
			eq0_q   <= (margin_q == rd_data_q);
		end
		if (state_q == ST_RDLO) begin
			hi_q <= rd_data_q;
		end
		if (div_start) begin
			rem_q     <= num_w[DATA_W-1:0];
			den_q     <= den_w[DATA_W-1:0];
			quo_q     <= '0;
			bit_cnt_q <= 3'd0;
		end else if (state_q == ST_DIV) begin
			rem_q     <= rem_d;
			quo_q     <= quo_d;
			bit_cnt_q <= bit_cnt_q + 3'd1;
		end
	end

endmodule

### design/ptint_chk.sv
// Port-level checker for the threshold interpolator, bound to the top level.
module ptint_chk import ptint_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             full,
	input logic             empty,
	input logic             pop,
	input logic [POD_W-1:0] pod_percent
);

	// reset leaves both queues empty
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> (empty && !full))
		else $error("queues not empty during reset");

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(pod_percent)))
		else $error("result changed while stalled");

	// results never pass the last percent level
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (int'(pod_percent) <= POD_MAX))
		else $error("result out of range");

	// below 1.00 the only result is zero
	a_low: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pod_percent < POD_ONE) |-> (pod_percent == POD_ZERO))
		else $error("fractional result below first level");

endmodule

bind pod_threshold_interpolator ptint_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.full        (full),
	.empty       (empty),
	.pop         (pop),
	.pod_percent (pod_percent)
);

### dv/pod_threshold_interpolator_tb.sv
// Self-checking testbench of the threshold interpolator: table loads and margin queries.
module pod_threshold_interpolator_tb import ptint_pkg::*; ();

	// The kind field: 0 loads one table entry, 1 asks for a probability.
	localparam bit KIND_WRITE = 1'b0;
	localparam bit KIND_QUERY = 1'b1;

	// Rough amount of stimulus, and the length of the receiver's long hold-off.
	localparam int ITEMS_TARGET = 1450;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 64;

	// Table shapes used by the stimulus.
	typedef enum int {
		SHAPE_STRICT,   // strictly ascending, random base and step size
		SHAPE_PLATEAU,  // ascending with runs of equal entries
		SHAPE_NOISE,    // random entries, no order at all
		SHAPE_SPAN,     // first entry at the most negative value, last at the most positive
		SHAPE_TIGHT     // steps of one, last entry at zero
	} shape_t;

	// Keeps its own copy of the threshold table and the probabilities still owed.
	class pod_scoreboard;
		int          thr[TABLE_ENTRIES];
		logic [POD_W-1:0] pod_expected[$];
		int errors, n_writes, n_dropped, n_queries, n_results;
		int n_zero, n_one, n_top, n_interp;

		// Lower-bound search with the same fixed step pattern as the block.
		function int first_not_below(int m);
			int first, count, half, probe;
			first = 0;
			count = TABLE_ENTRIES;
			while (count > 0) begin
				half  = count / 2;
				probe = first + half;
				if (thr[probe] < m) begin
					first = probe + 1;
					count -= half + 1;
				end else begin
					count = half;
				end
			end
			return first;
		endfunction

		function logic [POD_W-1:0] predict_pod(int m);
			int slot;
			longint num, den, frac;
			if (m > 0 || m < thr[0])
				return POD_ZERO;
			if (m == thr[0])
				return POD_ONE;
			if (m >= thr[TABLE_ENTRIES-1])
				return POD_TOP;
			slot = first_not_below(m);
			if (slot == 0)
				return POD_ZERO;
			if (slot >= TABLE_ENTRIES)
				return POD_TOP;
			num  = longint'(m) - thr[slot-1];
			den  = longint'(thr[slot]) - thr[slot-1];
			frac = 0;
			// fraction is truncated and never passes one whole step
			if (den > 0 && num > 0) begin
				frac = (num * 256) / den;
				if (frac > 256)
					frac = 256;
			end
			return POD_W'(longint'(slot) * 256 + frac);
		endfunction

		function void note_item(bit k, logic [KIDX_W-1:0] idx,
		                        logic signed [DATA_W-1:0] val,
		                        logic signed [DATA_W-1:0] mar);
			logic [POD_W-1:0] e;
			if (k == KIND_WRITE) begin
				if (idx < TABLE_ENTRIES) begin
					thr[idx] = val;
					n_writes++;
				end else begin
					n_dropped++;
				end
			end else begin
				e = predict_pod(mar);
				pod_expected.push_back(e);
				n_queries++;
				if (e == POD_ZERO)
					n_zero++;
				else if (e == POD_ONE)
					n_one++;
				else if (e == POD_TOP)
					n_top++;
				else
					n_interp++;
			end
		endfunction

		function void check_pod(logic [POD_W-1:0] got);
			logic [POD_W-1:0] e;
			n_results++;
			if (pod_expected.size() == 0) begin
				errors++;
				$display("%0t: pod_percent expected none, got %0d", $time, got);
			end else begin
				e = pod_expected.pop_front();
				if (got !== e) begin
					errors++;
					$display("%0t: pod_percent expected %0d, got %0d", $time, e, got);
				end
			end
		endfunction

		function int pending();
			return pod_expected.size();
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     push;
	logic                     full;
	logic                     kind;
	logic [KIDX_W-1:0]        entry_index;
	logic signed [DATA_W-1:0] entry_value;
	logic signed [DATA_W-1:0] margin_db;
	logic                     empty;
	logic                     pop;
	logic [POD_W-1:0]         pod_percent;

	pod_scoreboard sb = new();

	// The table the stimulus intends, used to aim margins at interesting spots.
	int     plan[TABLE_ENTRIES];
	shape_t shape;
	int     items_sent;
	int     tables_loaded;
	bit     tx_burst;

	pod_threshold_interpolator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.kind        (kind),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.margin_db   (margin_db),
		.empty       (empty),
		.pop         (pop),
		.pod_percent (pod_percent)
	);

	always #5 clk = ~clk;

	// Mostly no gap or a short one, now and then a long one; none at all in a burst.
	function automatic int pick_gap(bit burst);
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [DATA_W-1:0] rand24();
		return DATA_W'($urandom);
	endfunction

	// Entered just after a falling edge; leaves just after the next falling edge
	// following acceptance.
	task automatic send_item(bit k, logic [KIDX_W-1:0] idx,
	                         logic signed [DATA_W-1:0] val,
	                         logic signed [DATA_W-1:0] mar);
		int gap;
		gap = pick_gap(tx_burst);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push        <= 1'b1;
		kind        <= k;
		entry_index <= idx;
		entry_value <= val;
		margin_db   <= mar;
		do @(posedge clk); while (full);
		sb.note_item(k, idx, val, mar);
		if (k == KIND_QUERY || idx < TABLE_ENTRIES)
			items_sent++;
		@(negedge clk);
	endtask

	// Unused fields carry random bits so every port bit toggles.
	task automatic write_entry(int idx, int val);
		send_item(KIND_WRITE, KIDX_W'(idx), DATA_W'(val), rand24());
	endtask

	task automatic ask_pod(int m);
		send_item(KIND_QUERY, KIDX_W'($urandom), rand24(), DATA_W'(m));
	endtask

	task automatic build_plan(shape_t s);
		int smax, total, base;
		int steps[TABLE_ENTRIES];
		case (s)
			SHAPE_SPAN: begin
				for (int i = 0; i < TABLE_ENTRIES; i++)
					plan[i] = -8388608 + i * 84733;
				plan[TABLE_ENTRIES-1] = 8388607;
			end
			SHAPE_TIGHT: begin
				for (int i = 0; i < TABLE_ENTRIES; i++)
					plan[i] = i - (TABLE_ENTRIES - 1);
			end
			SHAPE_NOISE: begin
				for (int i = 0; i < TABLE_ENTRIES; i++)
					plan[i] = rand24();
			end
			default: begin
				case ($urandom_range(0, 2))
					0: smax = 3;
					1: smax = 1000;
					default: smax = 84000;
				endcase
				total = 0;
				for (int i = 1; i < TABLE_ENTRIES; i++) begin
					if (s == SHAPE_PLATEAU && $urandom_range(0, 2) == 0)
						steps[i] = 0;
					else
						steps[i] = $urandom_range(1, smax);
					total += steps[i];
				end
				// half the tables straddle zero, the rest sit anywhere that fits
				if ($urandom_range(0, 1))
					base = int'($urandom_range(0, total)) - total;
				else
					base = -8388608 + int'($urandom_range(0, 16777215 - total));
				plan[0] = base;
				for (int i = 1; i < TABLE_ENTRIES; i++)
					plan[i] = plan[i-1] + steps[i];
			end
		endcase
	endtask

	// Loads every slot, in shuffled order most of the time, with the odd
	// out-of-range write mixed in; those must leave the table alone.
	task automatic load_table();
		int order[$];
		for (int i = 0; i < TABLE_ENTRIES; i++)
			order.push_back(i);
		if ($urandom_range(0, 3) != 0)
			order.shuffle();
		foreach (order[j]) begin
			if ($urandom_range(0, 39) == 0)
				write_entry($urandom_range(TABLE_ENTRIES, 127), rand24());
			write_entry(order[j], plan[order[j]]);
		end
		tables_loaded++;
	endtask

	function automatic int pick_margin();
		int k, top;
		k = $urandom_range(0, TABLE_ENTRIES - 1);
		case ($urandom_range(0, 15))
			0:       return rand24();
			1, 2:    return plan[k];
			3:       return plan[k] + ($urandom_range(0, 1) ? 1 : -1);
			4:       return plan[0] - $urandom_range(0, 1);
			5:       return plan[TABLE_ENTRIES-1] - $urandom_range(0, 1);
			6: begin
				case ($urandom_range(0, 4))
					0:       return 0;
					1:       return 1;
					2:       return -1;
					3:       return -8388608;
					default: return 8388607;
				endcase
			end
			default: begin
				// somewhere inside the table and not above zero
				top = (plan[TABLE_ENTRIES-1] < 0) ? plan[TABLE_ENTRIES-1] : 0;
				if (plan[0] <= top)
					return plan[0] + int'($urandom_range(0, top - plan[0]));
				return rand24();
			end
		endcase
	endfunction

	// A rewrite mid-stream; on ordered tables the new value stays between
	// its neighbours so the table keeps its order.
	task automatic rewrite_entry();
		int k, span;
		k = $urandom_range(1, TABLE_ENTRIES - 2);
		if (shape == SHAPE_NOISE) begin
			plan[k] = rand24();
			write_entry(k, plan[k]);
		end else if (shape == SHAPE_STRICT) begin
			span = plan[k+1] - plan[k-1];
			if (span >= 2) begin
				plan[k] = plan[k-1] + 1 + int'($urandom_range(0, span - 2));
				write_entry(k, plan[k]);
			end
		end
	endtask

	// Stimulus: directed tables and queries, then random phases.
	initial begin
		int directed_span[$];
		int directed_tight[$];
		int n_items;
		arst_n      <= 1'b0;
		push        <= 1'b0;
		kind        <= KIND_WRITE;
		entry_index <= '0;
		entry_value <= '0;
		margin_db   <= '0;
		items_sent    = 0;
		tables_loaded = 0;
		tx_burst      = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Full-range table: both field extremes, zero and its neighbours,
		// exact hits and near misses around entries.
		shape = SHAPE_SPAN;
		build_plan(shape);
		load_table();
		directed_span = '{-8388608, 8388607, 0, 1, -1, plan[50], plan[50] + 1,
		                  plan[50] - 1, plan[1] - 1, plan[1], plan[49] + 1};
		foreach (directed_span[i])
			ask_pod(directed_span[i]);

		// Steps of one ending at zero: the fraction reaches a whole step,
		// the last entry is met exactly, below the first gives zero.
		shape = SHAPE_TIGHT;
		build_plan(shape);
		load_table();
		write_entry(TABLE_ENTRIES, 8388607);
		write_entry(127, -8388608);
		directed_tight = '{0, -99, -100, -50, -1, 1, -98, -2, -8388608};
		foreach (directed_tight[i])
			ask_pod(directed_tight[i]);

		// Random phases: mostly ordered tables, some plateaus and some noise.
		while (items_sent < ITEMS_TARGET) begin
			case ($urandom_range(0, 19))
				0, 1, 2:  shape = SHAPE_PLATEAU;
				3, 4:     shape = SHAPE_NOISE;
				5:        shape = SHAPE_SPAN;
				6:        shape = SHAPE_TIGHT;
				default:  shape = SHAPE_STRICT;
			endcase
			tx_burst = ($urandom_range(0, 3) == 0);
			build_plan(shape);
			load_table();
			n_items = $urandom_range(60, 160);
			for (int i = 0; i < n_items; i++) begin
				if ($urandom_range(0, 9) == 0)
					rewrite_entry();
				else
					ask_pod(pick_margin());
			end
		end
		push <= 1'b0;

		// Drain, then give the back end time to show any stray result.
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d table writes, %0d out-of-range writes, %0d queries, %0d tables",
		         sb.n_writes, sb.n_dropped, sb.n_queries, tables_loaded);
		$display("Results: %0d zero, %0d at first entry, %0d at top, %0d interpolated",
		         sb.n_zero, sb.n_one, sb.n_top, sb.n_interp);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Result side: random pop gaps, bursts of back-to-back pops, and twice a
	// long hold-off so the result queue and then the command queue fill up.
	initial begin
		int gap, popped;
		bit rx_burst;
		pop      <= 1'b0;
		popped   = 0;
		rx_burst = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (popped == 120 || popped == 640)
				gap = HOLD_CYCLES;
			else
				gap = pick_gap(rx_burst);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			sb.check_pod(pod_percent);
			popped++;
			if (popped % 64 == 0)
				rx_burst = ($urandom_range(0, 3) == 0);
			@(negedge clk);
		end
	end

	// Watchdog, well beyond the slowest legal run.
	initial begin
		#8000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
